>>> design/krt_pkg.sv
`timescale 1ns / 1ps
package krt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int LIST_MAX  = 16;
    localparam int CNT_W     = 5;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_DEL   = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_COUNT = 3'd3;
    localparam logic [2:0] CMD_LIST  = 3'd4;

    localparam logic [7:0]       SCORE_MAX = 8'd100;
    localparam logic [CNT_W-1:0] MAX_RESET = 5'd10;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] key;
        logic [7:0] year_in;
        logic [7:0] item_code_a;
        logic [7:0] item_code_b;
        logic [7:0] item_code_c;
        logic [7:0] score_a;
        logic [7:0] score_b;
        logic [7:0] score_c;
    } t_in;

    typedef struct packed {
        logic             ok;
        logic [7:0]       year_out;
        logic [7:0]       code_out_a;
        logic [7:0]       code_out_b;
        logic [7:0]       code_out_c;
        logic [7:0]       score_out_a;
        logic [7:0]       score_out_b;
        logic [7:0]       score_out_c;
        logic [CNT_W-1:0] entry_count;
        logic [7:0]       listed_key;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [7:0] key;
        logic [7:0] year;
        logic [7:0] code_a;
        logic [7:0] code_b;
        logic [7:0] code_c;
        logic [7:0] score_a;
        logic [7:0] score_b;
        logic [7:0] score_c;
    } t_rec;

    typedef struct packed {
        logic idle;
        logic load_item;
        logic idx_clr;
        logic idx_held;
        logic idx_inc;
        logic idx_dec;
        logic rd_en;
        logic rd_prev;
        logic wr_shift;
        logic wr_new;
        logic wr_keep;
        logic held_inc;
        logic held_from_n;
        logic ok_set;
        logic rec_load;
        logic out_list;
        logic out_resp;
    } t_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       add_ok;
        logic       idx_zero;
        logic       idx_at_held;
        logic       idx_last_list;
        logic       held_zero;
        logic       key_match;
        logic       out_free;
    } t_stat;

endpackage

>>> design/krt_ram.sv
`timescale 1ns / 1ps
module krt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/krt_ctrl.sv
`timescale 1ns / 1ps
module krt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  krt_pkg::t_stat i_stat,
    output krt_pkg::t_ctl  o_ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_ADD_RD   = 4'd2;
    localparam logic [3:0] S_ADD_WR   = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_USE  = 4'd5;
    localparam logic [3:0] S_RD_RD    = 4'd6;
    localparam logic [3:0] S_RD_USE   = 4'd7;
    localparam logic [3:0] S_LIST_RD  = 4'd8;
    localparam logic [3:0] S_LIST_USE = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                o_ctl.idle = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    krt_pkg::CMD_ADD: begin
                        if (i_stat.add_ok) begin
                            o_ctl.idx_held = 1'b1;
                            n_state        = S_ADD_RD;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    krt_pkg::CMD_DEL: begin
                        o_ctl.idx_clr = 1'b1;
                        n_state       = S_DEL_RD;
                    end
                    krt_pkg::CMD_READ: begin
                        o_ctl.idx_clr = 1'b1;
                        n_state       = S_RD_RD;
                    end
                    krt_pkg::CMD_LIST: begin
                        o_ctl.idx_clr = 1'b1;
                        n_state       = i_stat.held_zero ? S_RESP : S_LIST_RD;
                    end
                    krt_pkg::CMD_COUNT: begin
                        n_state = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_ADD_RD: begin
                if (i_stat.idx_zero) begin
                    o_ctl.wr_new   = 1'b1;
                    o_ctl.held_inc = 1'b1;
                    o_ctl.ok_set   = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_prev = 1'b1;
                    n_state       = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                o_ctl.wr_shift = 1'b1;
                o_ctl.idx_dec  = 1'b1;
                n_state        = S_ADD_RD;
            end
            S_DEL_RD: begin
                if (i_stat.idx_at_held) begin
                    o_ctl.held_from_n = 1'b1;
                    n_state           = S_RESP;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = S_DEL_USE;
                end
            end
            S_DEL_USE: begin
                o_ctl.wr_keep = !i_stat.key_match;
                o_ctl.idx_inc = 1'b1;
                n_state       = S_DEL_RD;
            end
            S_RD_RD: begin
                if (i_stat.idx_at_held) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = S_RD_USE;
                end
            end
            S_RD_USE: begin
                if (i_stat.key_match) begin
                    o_ctl.ok_set   = 1'b1;
                    o_ctl.rec_load = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_RD_RD;
                end
            end
            S_LIST_RD: begin
                o_ctl.rd_en = 1'b1;
                n_state     = S_LIST_USE;
            end
            S_LIST_USE: begin
                if (i_stat.out_free) begin
                    o_ctl.out_list = 1'b1;
                    o_ctl.idx_inc  = 1'b1;
                    n_state        = i_stat.idx_last_list ? S_IDLE : S_LIST_RD;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctl.out_resp = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/krt_dp.sv
`timescale 1ns / 1ps
module krt_dp #(
    parameter int SLOTS = krt_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  krt_pkg::t_ctl             i_ctl,
    output krt_pkg::t_stat            o_stat,
    input  krt_pkg::t_in              i_in_data,
    input  logic                      i_cfg_valid,
    input  logic [krt_pkg::CNT_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    output krt_pkg::t_out             o_out_data,
    input  logic                      i_out_stall
);

    localparam int AW       = $clog2(SLOTS);
    localparam int CW       = $clog2(SLOTS + 1);
    localparam int CNT_W    = krt_pkg::CNT_W;
    localparam int MW       = (CW > CNT_W) ? CW : CNT_W;
    localparam int LIST_LIM = (SLOTS < krt_pkg::LIST_MAX) ? SLOTS : krt_pkg::LIST_MAX;
    localparam int REC_W    = $bits(krt_pkg::t_rec);

    krt_pkg::t_in      r_item;
    krt_pkg::t_rec     r_rec;
    krt_pkg::t_out     r_out;
    logic [CNT_W-1:0]  r_max;
    logic [CW-1:0]     r_held;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_n;
    logic              r_ok;
    logic              r_out_valid;

    krt_pkg::t_rec     w_rd;
    krt_pkg::t_rec     w_new;
    krt_pkg::t_rec     w_wr;
    krt_pkg::t_out     n_out;
    logic [REC_W-1:0]  w_rd_raw;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    logic              w_wr_en;
    logic [CW-1:0]     w_idx_m1;
    logic [CW-1:0]     w_idx_p1;
    logic [CW-1:0]     w_list_n;
    logic              w_out_free;
    logic              w_out_load;

    assign w_idx_m1   = r_idx - CW'(1);
    assign w_idx_p1   = r_idx + CW'(1);
    assign w_list_n   = (r_held > CW'(LIST_LIM)) ? CW'(LIST_LIM) : r_held;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = i_ctl.out_list || i_ctl.out_resp;
    assign w_rd       = krt_pkg::t_rec'(w_rd_raw);

    always_comb begin
        w_new.key     = r_item.key;
        w_new.year    = r_item.year_in;
        w_new.code_a  = r_item.item_code_a;
        w_new.code_b  = r_item.item_code_b;
        w_new.code_c  = r_item.item_code_c;
        w_new.score_a = r_item.score_a;
        w_new.score_b = r_item.score_b;
        w_new.score_c = r_item.score_c;
    end

    assign w_wr_en   = i_ctl.wr_new || i_ctl.wr_shift || i_ctl.wr_keep;
    assign w_wr      = i_ctl.wr_new ? w_new : w_rd;
    assign w_wr_addr = i_ctl.wr_new   ? '0 :
                       i_ctl.wr_shift ? r_idx[AW-1:0] : r_n[AW-1:0];
    assign w_rd_addr = i_ctl.rd_prev ? w_idx_m1[AW-1:0] : r_idx[AW-1:0];

    krt_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    always_comb begin
        o_stat.cmd           = r_item.cmd;
        o_stat.add_ok        = (MW'(r_held) < MW'(r_max)) && (r_held < CW'(SLOTS)) &&
                               (r_item.score_a <= krt_pkg::SCORE_MAX) &&
                               (r_item.score_b <= krt_pkg::SCORE_MAX) &&
                               (r_item.score_c <= krt_pkg::SCORE_MAX);
        o_stat.idx_zero      = (r_idx == '0);
        o_stat.idx_at_held   = (r_idx == r_held);
        o_stat.idx_last_list = (w_idx_p1 == w_list_n);
        o_stat.held_zero     = (r_held == '0);
        o_stat.key_match     = (w_rd.key == r_item.key);
        o_stat.out_free      = w_out_free;
    end

    always_comb begin
        n_out             = '0;
        n_out.entry_count = CNT_W'(r_held);
        n_out.last        = 1'b1;
        if (i_ctl.out_list) begin
            n_out.ok         = 1'b1;
            n_out.listed_key = w_rd.key;
            n_out.last       = o_stat.idx_last_list;
        end else begin
            n_out.ok = r_ok;
            if (r_ok && (r_item.cmd == krt_pkg::CMD_READ)) begin
                n_out.year_out    = r_rec.year;
                n_out.code_out_a  = r_rec.code_a;
                n_out.code_out_b  = r_rec.code_b;
                n_out.code_out_c  = r_rec.code_c;
                n_out.score_out_a = r_rec.score_a;
                n_out.score_out_b = r_rec.score_b;
                n_out.score_out_c = r_rec.score_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= krt_pkg::MAX_RESET;
            r_held      <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_ctl.idle && !i_ctl.load_item) begin
                r_max <= i_cfg_data;
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
                r_n   <= '0;
            end else begin
                if (i_ctl.idx_held) begin
                    r_idx <= r_held;
                end else if (i_ctl.idx_inc) begin
                    r_idx <= w_idx_p1;
                end else if (i_ctl.idx_dec) begin
                    r_idx <= w_idx_m1;
                end
                if (i_ctl.wr_keep) begin
                    r_n <= r_n + CW'(1);
                end
            end
            if (i_ctl.held_inc) begin
                r_held <= r_held + CW'(1);
            end else if (i_ctl.held_from_n) begin
                r_held <= r_n;
            end
            if (i_ctl.load_item) begin
                r_ok <= 1'b0;
            end else if (i_ctl.ok_set) begin
                r_ok <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_item <= i_in_data;
        end
        if (i_ctl.rec_load) begin
            r_rec <= w_rd;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(SLOTS))
        else $error("record count above table size");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while held");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_ctl.wr_new, i_ctl.wr_shift, i_ctl.wr_keep}))
        else $error("conflicting table writes");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_keep |-> (r_n <= r_idx))
        else $error("compaction write overtakes the scan");

    a_held_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.held_inc |=> (r_held == $past(r_held) + CW'(1)))
        else $error("record count did not advance by one");

endmodule

>>> design/keyed_record_table_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_in_data   (krt_pkg::t_in)
// result    out        o_out_valid / i_out_stall    o_out_data  (krt_pkg::t_out)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_data  (max_entries)
//
// One transaction is handled at a time; every record move goes through the single
// read port of the record RAM, which costs a read state and a following state per
// record visited. Each result, and each listed key, waits while the result side stalls.
// Reset is synchronous and clears the count and sets the limit to 10; the record
// RAM is not cleared. The next transaction is taken while a result is still held.
module keyed_record_table_core #(
    parameter int SLOTS = krt_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  krt_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output krt_pkg::t_out             o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [krt_pkg::CNT_W-1:0] i_cfg_data
);

    krt_pkg::t_ctl  w_ctl;
    krt_pkg::t_stat w_stat;

    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    krt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    assign o_in_stall  = !w_ctl.idle || !i_rst_n;
    assign o_cfg_ready = w_ctl.idle && !w_ctl.load_item && i_rst_n;

endmodule
